// ===== sv/lag_pkg.sv =====
// Shared constants, codes and control types for the life automaton grid.
`default_nettype none
package lag_pkg;

  // Grid geometry
  localparam int GRID_SIDE = 32;
  localparam int IDX_W     = $clog2(GRID_SIDE);
  localparam int SIDE_W    = $clog2(GRID_SIDE + 1);

  // Field widths
  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int SIZE_W     = 6;
  localparam int LIMIT_W    = 4;
  localparam int COUNT_W    = 4;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVERCROWD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONELY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH       = 3'd3;

  // Register reset values
  localparam logic [SIZE_W-1:0]  RST_ACTIVE_SIZE = 6'd32;
  localparam logic [LIMIT_W-1:0] RST_OVERCROWD   = 4'd3;
  localparam logic [LIMIT_W-1:0] RST_LONELY      = 4'd2;
  localparam logic [LIMIT_W-1:0] RST_BIRTH       = 4'd3;
  localparam int                 MIN_SIDE        = 3;

  // Broadcast control shared by every cell
  typedef struct packed {
    logic               step;
    logic               wr;
    logic               wr_val;
    logic [LIMIT_W-1:0] overcrowd;
    logic [LIMIT_W-1:0] lonely;
    logic [LIMIT_W-1:0] birth;
  } lag_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/lag_cell.sv =====
// One grid cell: holds its state and applies the life rule from its neighbors.
`default_nettype none
module lag_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lag_pkg::lag_ctrl_t ctrl,
  input  wire logic               wr_sel,
  input  wire logic               interior,
  input  wire logic [7:0]         nbr,
  output logic                    alive
);
  import lag_pkg::*;

  logic [COUNT_W-1:0] cnt;
  logic               rule;
  logic               alive_next;

  // Count live neighbors and apply survival or birth; a write to this cell takes priority
  always_comb begin
    cnt = COUNT_W'($countones(nbr));
    if (alive) begin
      rule = !(cnt > ctrl.overcrowd) && !(cnt < ctrl.lonely);
    end else begin
      rule = (cnt == ctrl.birth);
    end
    alive_next = alive;
    if (ctrl.wr && wr_sel) begin
      alive_next = ctrl.wr_val;
    end else if (ctrl.step && interior) begin
      alive_next = rule;
    end
  end

  // Hold state, clear at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      alive <= 1'b0;
    end else begin
      alive <= alive_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lag_array.sv =====
// Square array of life cells with neighbor wiring, write decode and read select.
`default_nettype none
module lag_array (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lag_pkg::lag_ctrl_t          ctrl,
  input  wire logic [lag_pkg::SIDE_W-1:0]  side,
  input  wire logic [lag_pkg::IDX_W-1:0]   sel_row,
  input  wire logic [lag_pkg::IDX_W-1:0]   sel_col,
  output logic                             rd_cell
);
  import lag_pkg::*;

  logic [GRID_SIDE-1:0] cells [GRID_SIDE];
  logic [GRID_SIDE+1:0] pad   [GRID_SIDE+2];
  logic [GRID_SIDE-1:0] interior_line;
  logic [GRID_SIDE-1:0] row_hit;
  logic [GRID_SIDE-1:0] col_hit;

  // Interior test and address decode per line index
  for (genvar i = 0; i < GRID_SIDE; i++) begin : g_line
    localparam logic [SIDE_W-1:0] NEXT_IDX = SIDE_W'(i + 1);
    if (i == 0) begin : g_first
      assign interior_line[i] = 1'b0;
    end else begin : g_rest
      assign interior_line[i] = (NEXT_IDX < side);
    end
    assign row_hit[i] = (sel_row == IDX_W'(i));
    assign col_hit[i] = (sel_col == IDX_W'(i));
  end

  // Zero frame around the grid so edge cells see dead outside neighbors
  assign pad[0]           = '0;
  assign pad[GRID_SIDE+1] = '0;
  for (genvar r = 0; r < GRID_SIDE; r++) begin : g_pad
    assign pad[r+1] = {1'b0, cells[r], 1'b0};
  end

  // Cell grid
  for (genvar r = 0; r < GRID_SIDE; r++) begin : g_row
    for (genvar c = 0; c < GRID_SIDE; c++) begin : g_col
      logic [7:0] nbr;
      assign nbr = {pad[r][c], pad[r][c+1], pad[r][c+2],
                    pad[r+1][c],            pad[r+1][c+2],
                    pad[r+2][c], pad[r+2][c+1], pad[r+2][c+2]};
      lag_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .wr_sel   (row_hit[r] & col_hit[c]),
        .interior (interior_line[r] & interior_line[c]),
        .nbr      (nbr),
        .alive    (cells[r][c])
      );
    end
  end

  // Read select
  assign rd_cell = cells[sel_row][sel_col];

endmodule
`default_nettype wire

// ===== sv/life_automaton_grid_unit.sv =====
// Top level of the life automaton grid: config registers, request decode, result buffer.
// Usage:
//   Requests arrive on req_valid/req_stall with func, row, col and cell_in.
//   func selects a cell write, one generation advance, or a cell read.
//   Each request yields exactly one result on rsp_valid/rsp_stall carrying
//   cell_out and out_of_range.
//   A taken request's result is registered in the result register, or in the skid entry while the receiver stalls.
//   Throughput: one request per cycle while req_stall is low; a whole
//   generation is computed in parallel by the array of per-position cells,
//   each counting its eight neighbors from its neighbors' registers.
//   The receiver may stall: a result register plus one skid entry hold
//   results, and req_stall rises only while the skid entry is occupied.
//   Configuration writes use cfg_valid/cfg_ready (always ready) with a
//   register index and data; write only while no request is in flight.
//   Reset (rst, synchronous) clears every cell to dead, loads the default
//   size and rule limits, and empties the result buffer.
`default_nettype none
module life_automaton_grid_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic [lag_pkg::FUNC_W-1:0]      func,
  input  wire logic [lag_pkg::COORD_W-1:0]     row,
  input  wire logic [lag_pkg::COORD_W-1:0]     col,
  input  wire logic                            cell_in,
  // result channel
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic                                 cell_out,
  output logic                                 out_of_range,
  // configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lag_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lag_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lag_pkg::*;

  localparam int CMP_W = SIDE_W + SIZE_W;

  logic [SIZE_W-1:0]  active_size;
  logic [LIMIT_W-1:0] overcrowd_limit;
  logic [LIMIT_W-1:0] lonely_limit;
  logic [LIMIT_W-1:0] birth_count;

  logic [SIDE_W-1:0]  side;
  logic               accept;
  logic               in_grid;
  logic               is_write;
  logic               is_step;
  logic               is_read;
  logic               rd_cell;
  logic               res_cell;
  logic               res_oor;
  lag_ctrl_t          ctrl;

  logic               skid_valid;
  logic               skid_cell;
  logic               skid_oor;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_size     <= RST_ACTIVE_SIZE;
      overcrowd_limit <= RST_OVERCROWD;
      lonely_limit    <= RST_LONELY;
      birth_count     <= RST_BIRTH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTIVE_SIZE: active_size     <= cfg_data[SIZE_W-1:0];
        REG_OVERCROWD:   overcrowd_limit <= cfg_data[LIMIT_W-1:0];
        REG_LONELY:      lonely_limit    <= cfg_data[LIMIT_W-1:0];
        REG_BIRTH:       birth_count     <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the active size to the supported range
  always_comb begin
    if (CMP_W'(active_size) < CMP_W'(MIN_SIDE)) begin
      side = SIDE_W'(MIN_SIDE);
    end else if (CMP_W'(active_size) > CMP_W'(GRID_SIDE)) begin
      side = SIDE_W'(GRID_SIDE);
    end else begin
      side = SIDE_W'(active_size);
    end
  end

  // Decode the request
  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign is_write  = (func == FUNC_WRITE);
  assign is_step   = (func == FUNC_STEP);
  assign is_read   = (func == FUNC_READ);
  assign in_grid   = (CMP_W'(row) < CMP_W'(side)) && (CMP_W'(col) < CMP_W'(side));

  always_comb begin
    ctrl           = '0;
    ctrl.step      = accept && is_step;
    ctrl.wr        = accept && is_write && in_grid;
    ctrl.wr_val    = cell_in;
    ctrl.overcrowd = overcrowd_limit;
    ctrl.lonely    = lonely_limit;
    ctrl.birth     = birth_count;
  end

  lag_array u_array (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .side    (side),
    .sel_row (IDX_W'(row)),
    .sel_col (IDX_W'(col)),
    .rd_cell (rd_cell)
  );

  // Result fields
  assign res_cell = is_read && in_grid && rd_cell;
  assign res_oor  = (is_write || is_read) && !in_grid;

  // Result register with one skid entry: advance when the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        rsp_valid  <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        cell_out     <= skid_cell;
        out_of_range <= skid_oor;
      end else if (accept) begin
        cell_out     <= res_cell;
        out_of_range <= res_oor;
      end
    end else if (accept) begin
      skid_cell <= res_cell;
      skid_oor  <= res_oor;
    end
  end

endmodule
`default_nettype wire
